// ===== design/assert_macros.svh =====
// Assertion helpers used by peak_normalize_factor.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== design/pnf_pkg.sv =====
`timescale 1ns / 1ps

package pnf_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int MAX_TRACES     = 64;
    localparam int GAIN_BITS      = 48;
    localparam int INDEX_BITS     = 6;
    localparam int SCALE_BITS     = 32;
    localparam int SCALE_FRAC     = 16;
    localparam int COUNT_BITS     = $clog2(MAX_TRACES + 1);
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 32;
    localparam int DIV_STEP_BITS  = $clog2(GAIN_BITS);

    localparam logic [GAIN_BITS-1:0]  UNITY_GAIN  = GAIN_BITS'(64'd1 << 32);
    localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(65536);

    typedef enum logic [1:0] {
        MODE_UNITY       = 2'd0,
        MODE_FIXED       = 2'd1,
        MODE_TRACE_PEAK  = 2'd2,
        MODE_GATHER_PEAK = 2'd3
    } pnf_mode_t;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCALE = 1'd1;

    // One unit of work for the back end: a gain (direct or to be divided)
    // issued to count consecutive trace indexes starting at base.
    typedef struct packed {
        logic                   divide;
        logic [GAIN_BITS-1:0]   value;
        logic [SAMPLE_BITS-1:0] divisor;
        logic [INDEX_BITS-1:0]  base;
        logic [COUNT_BITS-1:0]  count;
        logic                   last;
    } pnf_cmd_t;

endpackage

// ===== design/pnf_in_if.sv =====
`timescale 1ns / 1ps

interface pnf_in_if import pnf_pkg::*; ();

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          trace_end;
    logic                          gather_end;

    modport source (output valid, output sample, output trace_end, output gather_end,
                    input ready);
    modport sink   (input valid, input sample, input trace_end, input gather_end,
                    output ready);

endinterface

// ===== design/pnf_out_if.sv =====
`timescale 1ns / 1ps

interface pnf_out_if import pnf_pkg::*; ();

    logic                        valid;
    logic                        ready;
    logic signed [GAIN_BITS-1:0] gain;
    logic [INDEX_BITS-1:0]       trace_index;
    logic                        last;

    modport source (output valid, output gain, output trace_index, output last,
                    input ready);
    modport sink   (input valid, input gain, input trace_index, input last,
                    output ready);

endinterface

// ===== design/pnf_front.sv =====
`timescale 1ns / 1ps

module pnf_front import pnf_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    pnf_in_if.sink                       samples,
    input  pnf_mode_t                    mode,
    input  logic signed [SCALE_BITS-1:0] fixed_scale,
    output pnf_cmd_t                     cmd,
    output logic                         cmd_push,
    input  logic                         cmd_ready
);

    logic [SAMPLE_BITS-1:0] trace_peak_reg;
    logic [SAMPLE_BITS-1:0] gather_peak_reg;
    logic [COUNT_BITS-1:0]  count_reg;

    logic [SAMPLE_BITS-1:0] mag;
    logic [SAMPLE_BITS-1:0] trace_peak_next;
    logic [SAMPLE_BITS-1:0] gather_peak_next;
    logic [COUNT_BITS-1:0]  count_inc;
    logic [INDEX_BITS-1:0]  idx;
    logic [GAIN_BITS-1:0]   numer;
    logic                   accept;
    logic                   tend;
    logic                   gend;
    logic                   below_max;

    assign samples.ready = cmd_ready;
    assign accept        = samples.valid && cmd_ready;
    assign gend          = samples.gather_end;
    assign tend          = samples.trace_end || samples.gather_end;

    // Most negative sample maps onto 2^(SAMPLE_BITS-1), still exact unsigned.
    assign mag = samples.sample[SAMPLE_BITS-1]
               ? (~samples.sample) + SAMPLE_BITS'(1)
               : samples.sample;

    assign trace_peak_next  = (mag > trace_peak_reg)  ? mag : trace_peak_reg;
    assign gather_peak_next = (mag > gather_peak_reg) ? mag : gather_peak_reg;

    assign below_max = count_reg < COUNT_BITS'(MAX_TRACES);
    assign count_inc = below_max ? count_reg + COUNT_BITS'(1) : count_reg;
    assign idx       = below_max ? INDEX_BITS'(count_reg) : INDEX_BITS'(MAX_TRACES - 1);
    assign numer     = {fixed_scale, {SCALE_FRAC{1'b0}}};

    always_comb
    begin
        cmd.divide  = 1'b0;
        cmd.value   = '0;
        cmd.divisor = '0;
        cmd.base    = idx;
        cmd.count   = COUNT_BITS'(1);
        cmd.last    = gend;
        if (mode == MODE_GATHER_PEAK)
        begin
            // one gain for every trace counted in the gather
            cmd.base    = '0;
            cmd.count   = count_inc;
            cmd.last    = 1'b1;
            cmd.divide  = (gather_peak_next != '0);
            cmd.value   = (gather_peak_next != '0) ? numer : '0;
            cmd.divisor = gather_peak_next;
        end
        else
        begin
            case (mode)
                MODE_UNITY:
                begin
                    cmd.value = UNITY_GAIN;
                end
                MODE_FIXED:
                begin
                    cmd.value = numer;
                end
                MODE_TRACE_PEAK:
                begin
                    cmd.divide  = (trace_peak_next != '0);
                    cmd.value   = (trace_peak_next != '0) ? numer : '0;
                    cmd.divisor = trace_peak_next;
                end
                default:
                begin
                    cmd.value = '0;
                end
            endcase
        end
    end

    assign cmd_push = accept && tend && ((mode != MODE_GATHER_PEAK) || gend);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trace_peak_reg  <= '0;
            gather_peak_reg <= '0;
            count_reg       <= '0;
        end
        else if (accept)
        begin
            trace_peak_reg  <= tend ? '0 : trace_peak_next;
            gather_peak_reg <= gend ? '0 : gather_peak_next;
            if (tend)
            begin
                count_reg <= gend ? '0 : count_inc;
            end
        end
    end

endmodule

// ===== design/pnf_queue.sv =====
`timescale 1ns / 1ps

module pnf_queue import pnf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  pnf_cmd_t push_cmd,
    input  logic     push,
    output logic     push_ready,
    output pnf_cmd_t head,
    output logic     head_valid,
    input  logic     pop
);

    pnf_cmd_t                  entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   fill_reg;

    assign push_ready = fill_reg != (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH);
    assign head_valid = fill_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_BITS'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + (QUEUE_PTR_BITS + 1)'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - (QUEUE_PTR_BITS + 1)'(1);
            end
        end
    end

endmodule

// ===== design/pnf_back.sv =====
`timescale 1ns / 1ps

module pnf_back import pnf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  pnf_cmd_t cmd,
    input  logic     cmd_valid,
    output logic     cmd_pop,
    pnf_out_if.source gains
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    state_t                   state_reg;
    logic [GAIN_BITS-1:0]     quot_reg;
    logic [SAMPLE_BITS-1:0]   rem_reg;
    logic [SAMPLE_BITS-1:0]   div_reg;
    logic                     neg_reg;
    logic [DIV_STEP_BITS-1:0] step_reg;
    logic [INDEX_BITS-1:0]    idx_reg;
    logic [COUNT_BITS-1:0]    left_reg;
    logic                     last_flag_reg;
    logic                     out_valid_reg;
    logic [GAIN_BITS-1:0]     out_gain_reg;
    logic [INDEX_BITS-1:0]    out_index_reg;
    logic                     out_last_reg;

    logic [SAMPLE_BITS:0]   rem_shift;
    logic [SAMPLE_BITS:0]   rem_sub;
    logic                   fits;
    logic                   num_neg;
    logic [GAIN_BITS-1:0]   num_mag;
    logic [GAIN_BITS-1:0]   gain_val;
    logic                   out_free;
    logic                   emit;

    assign cmd_pop  = (state_reg == ST_IDLE) && cmd_valid;
    assign out_free = !out_valid_reg || gains.ready;
    assign emit     = (state_reg == ST_EMIT) && out_free;

    assign num_neg = cmd.value[GAIN_BITS-1];
    assign num_mag = num_neg ? (~cmd.value) + GAIN_BITS'(1) : cmd.value;

    // restoring division, one quotient bit a cycle
    assign rem_shift = {rem_reg, quot_reg[GAIN_BITS-1]};
    assign rem_sub   = rem_shift - {1'b0, div_reg};
    assign fits      = rem_shift >= {1'b0, div_reg};

    assign gain_val = neg_reg ? (~quot_reg) + GAIN_BITS'(1) : quot_reg;

    assign gains.valid       = out_valid_reg;
    assign gains.gain        = out_gain_reg;
    assign gains.trace_index = out_index_reg;
    assign gains.last        = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            quot_reg      <= '0;
            rem_reg       <= '0;
            div_reg       <= '0;
            neg_reg       <= 1'b0;
            step_reg      <= '0;
            idx_reg       <= '0;
            left_reg      <= '0;
            last_flag_reg <= 1'b0;
            out_gain_reg  <= '0;
            out_index_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (gains.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        idx_reg       <= cmd.base;
                        left_reg      <= cmd.count;
                        last_flag_reg <= cmd.last;
                        rem_reg       <= '0;
                        div_reg       <= cmd.divisor;
                        step_reg      <= DIV_STEP_BITS'(GAIN_BITS - 1);
                        if (cmd.divide)
                        begin
                            quot_reg  <= num_mag;
                            neg_reg   <= num_neg;
                            state_reg <= ST_DIVIDE;
                        end
                        else
                        begin
                            quot_reg  <= cmd.value;
                            neg_reg   <= 1'b0;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_DIVIDE:
                begin
                    rem_reg  <= fits ? rem_sub[SAMPLE_BITS-1:0] : rem_shift[SAMPLE_BITS-1:0];
                    quot_reg <= {quot_reg[GAIN_BITS-2:0], fits};
                    step_reg <= step_reg - DIV_STEP_BITS'(1);
                    if (step_reg == '0)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_gain_reg  <= gain_val;
                        out_index_reg <= idx_reg;
                        out_last_reg  <= last_flag_reg && (left_reg == COUNT_BITS'(1));
                        idx_reg       <= idx_reg + INDEX_BITS'(1);
                        left_reg      <= left_reg - COUNT_BITS'(1);
                        if (left_reg == COUNT_BITS'(1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/peak_normalize_factor.sv =====
// Peak normalisation gain: samples stream in one per cycle while the front end tracks
// trace and gather peaks; each trace end (or, in whole-gather mode, each gather end)
// queues one job in a four-entry queue. The back end takes one job at a time from the
// queue, runs it through its bit-serial restoring divider for the peak modes (not for
// unity or fixed gain), then issues one result a cycle while the output is not held
// by back-pressure (one per trace, up to 64 at a gather end). Sample intake holds at
// one per cycle until the queue fills, then stalls until the back end takes a job.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user must write
// it only while the block is idle, as the block itself does not enforce this.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module peak_normalize_factor import pnf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    pnf_in_if.sink                    samples,
    pnf_out_if.source                 gains,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    pnf_mode_t               mode_reg;
    logic [SCALE_BITS-1:0]   scale_reg;

    pnf_cmd_t q_in;
    pnf_cmd_t q_head;
    logic     q_push;
    logic     q_ready;
    logic     q_valid;
    logic     q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_UNITY;
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MODE:
                begin
                    mode_reg <= pnf_mode_t'(cfg_data[1:0]);
                end
                CFG_SCALE:
                begin
                    scale_reg <= cfg_data[SCALE_BITS-1:0];
                end
                default:
                begin
                    mode_reg <= mode_reg;
                end
            endcase
        end
    end

    pnf_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples),
        .mode        (mode_reg),
        .fixed_scale (scale_reg),
        .cmd         (q_in),
        .cmd_push    (q_push),
        .cmd_ready   (q_ready)
    );

    pnf_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (q_in),
        .push       (q_push),
        .push_ready (q_ready),
        .head       (q_head),
        .head_valid (q_valid),
        .pop        (q_pop)
    );

    pnf_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_head),
        .cmd_valid (q_valid),
        .cmd_pop   (q_pop),
        .gains     (gains)
    );

    `ASSERT_IMPLIES(a_push_has_room, clk, rst_n, q_push, q_ready)
    `ASSERT_IMPLIES(a_pop_has_entry, clk, rst_n, q_pop, q_valid)
    `ASSERT_IMPLIES(a_push_on_trace_end, clk, rst_n, q_push,
        samples.valid && samples.ready && (samples.trace_end || samples.gather_end))
    `ASSERT_NEXT(a_full_blocks_intake, clk, rst_n, q_valid && !q_pop && !q_ready,
        !q_ready || q_pop)

endmodule
